// File: rtl/rvcs_pkg.sv
// ----------------------------------------------------------------------------
// rvcs_pkg
// Shared types, register indexes, widths and the 2-bit level table of the
// voltage channel slicer.
// ----------------------------------------------------------------------------
package rvcs_pkg;

    localparam int DEFAULT_OFFSET_BITS = 28;
    localparam int STRIDE_W            = 29;
    localparam int IDX_W               = 28;
    localparam int VAL_W               = 20;
    localparam int CFG_IDX_W           = 3;

    // ceil(2^30 / 3); exact quotient for any 29-bit dividend
    localparam logic [29:0] DIV3_MUL   = 30'h1555_5556;
    localparam int          DIV3_SHIFT = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EIGHT_BIT_MODE        = 3'd0,
        CFG_LAYOUT_SELECT         = 3'd1,
        CFG_SELECTED_CHANNEL      = 3'd2,
        CFG_SELECTED_POLARIZATION = 3'd3,
        CFG_POLS_PER_CHANNEL      = 3'd4,
        CFG_STRIDE_BYTES          = 3'd5,
        CFG_BLOCK_BYTES           = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] LAYOUT_TIME_MAJOR   = 2'd0;
    localparam logic [1:0] LAYOUT_CHAN_BLOCKED = 2'd1;
    localparam logic [1:0] LAYOUT_POL_INTERLV  = 2'd2;

    localparam logic [2:0]          RST_NPOL        = 3'd4;
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = 29'd256;
    localparam logic [STRIDE_W-1:0] RST_STRIDE_DIV3 = 29'd85;
    localparam logic [STRIDE_W-1:0] RST_BLOCK_BYTES = 29'd134217728;

    localparam logic signed [7:0] RANGE_MIN_INIT = 8'sd127;
    localparam logic signed [7:0] RANGE_MAX_INIT = -8'sd128;

    // Q8.12 levels for the four 2-bit codes
    function automatic logic signed [VAL_W-1:0] level_q12(input logic [1:0] code);
        logic signed [VAL_W-1:0] lvl;
        case (code)
            2'd0:    lvl = -20'sd13664;
            2'd1:    lvl = -20'sd4096;
            2'd2:    lvl = 20'sd4096;
            2'd3:    lvl = 20'sd13664;
            default: lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

// File: rtl/raw_voltage_channel_slicer_core.sv
// ----------------------------------------------------------------------------
// raw_voltage_channel_slicer_core
// Picks the bytes of one channel and polarization out of a voltage data
// block and decodes them to Q8.12 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one payload byte per
//   request, in block order. Output channel (o_out_valid / i_out_ready)
//   gives one sample request for each selected byte, plus one for the last
//   byte of a block (block_done set) even when that byte is not selected.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   write it only while no byte is in flight. Writes do not clear the block
//   counters.
//   The accepted byte sits in the input register and its result is loaded
//   into the result register once that register is free or being taken.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   processing stage holds the position compares and the unit-fit multiply
//   (unit index plus one, times stride) that decide selection.
//   Reset clears the block counters and the running range and loads the
//   register defaults. When the receiver stalls, the result register holds
//   and the input register fills, then o_in_ready drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module raw_voltage_channel_slicer_core #(
    parameter int OFFSET_BITS = rvcs_pkg::DEFAULT_OFFSET_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rvcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rvcs_pkg::STRIDE_W-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_payload_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rvcs_pkg::VAL_W-1:0]    o_sample_value,
    output logic [1:0]                           o_sample_code,
    output logic [rvcs_pkg::IDX_W-1:0]           o_sample_index,
    output logic signed [7:0]                    o_range_min,
    output logic signed [7:0]                    o_range_max,
    output logic                                 o_block_done
);
    import rvcs_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int CW = ((OB > STRIDE_W) ? OB : STRIDE_W) + 1;
    localparam int XW = CW + 2;
    localparam int PW = OB + 1 + STRIDE_W;
    localparam int DW = STRIDE_W + 30;

    // configuration registers
    logic                r_eight;
    logic [1:0]          r_layout;
    logic [5:0]          r_chan;
    logic [1:0]          r_pol;
    logic [2:0]          r_npol_raw;
    logic [STRIDE_W-1:0] r_stride;
    logic [STRIDE_W-1:0] r_stride_div3;
    logic [STRIDE_W-1:0] r_block_bytes;
    logic [DW-1:0]       div3_prod;

    assign div3_prod = DW'(i_cfg_data) * DW'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight       <= 1'b0;
            r_layout      <= LAYOUT_TIME_MAJOR;
            r_chan        <= '0;
            r_pol         <= '0;
            r_npol_raw    <= RST_NPOL;
            r_stride      <= RST_STRIDE;
            r_stride_div3 <= RST_STRIDE_DIV3;
            r_block_bytes <= RST_BLOCK_BYTES;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EIGHT_BIT_MODE:        r_eight    <= i_cfg_data[0];
                CFG_LAYOUT_SELECT:         r_layout   <= i_cfg_data[1:0];
                CFG_SELECTED_CHANNEL:      r_chan     <= i_cfg_data[5:0];
                CFG_SELECTED_POLARIZATION: r_pol      <= i_cfg_data[1:0];
                CFG_POLS_PER_CHANNEL:      r_npol_raw <= i_cfg_data[2:0];
                CFG_STRIDE_BYTES: begin
                    r_stride      <= i_cfg_data;
                    r_stride_div3 <= div3_prod[DIV3_SHIFT +: STRIDE_W];
                end
                CFG_BLOCK_BYTES:           r_block_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input and result registers
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [1:0]  r_out_code;
    logic [IDX_W-1:0] r_out_index;
    logic signed [7:0] r_out_min;
    logic signed [7:0] r_out_max;
    logic        r_out_done;

    // block state
    logic [OB-1:0] r_block_offset, n_block_offset;
    logic [OB-1:0] r_pos, n_pos;
    logic [OB-1:0] r_unit, n_unit;
    logic [1:0]    r_pol_phase, n_pol_phase;
    logic [OB-1:0] r_time, n_time;
    logic signed [7:0] r_run_min, n_run_min;
    logic signed [7:0] r_run_max, n_run_max;

    logic p_fire;
    logic p_emit;

    assign p_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || p_fire;

    // processing stage
    logic [2:0]          npol;
    logic [STRIDE_W-1:0] stride_div;
    logic [STRIDE_W-1:0] ulen;
    logic [STRIDE_W-1:0] len;
    logic [CW-1:0]       cap;
    logic [CW-1:0]       bb_ext;
    logic [CW-1:0]       bb_eff;
    logic [7:0]          target_cp;
    logic [7:0]          target_l0;
    logic [OB:0]         unit_p1;
    logic [PW-1:0]       unit_end;
    logic [OB:0]         time_p1;
    logic [XW-1:0]       time_span;
    logic                sel;
    logic                done;
    logic                wrap;
    logic [OB-1:0]       tidx;
    logic [1:0]          code;
    logic signed [7:0]   smp;
    logic signed [VAL_W-1:0] val;

    always_comb begin
        case (r_npol_raw)
            3'd0:    npol = 3'd1;
            3'd1:    npol = 3'd1;
            3'd2:    npol = 3'd2;
            3'd3:    npol = 3'd3;
            3'd4:    npol = 3'd4;
            default: npol = 3'd4;
        endcase
    end

    always_comb begin
        case (npol)
            3'd1:    stride_div = r_stride;
            3'd2:    stride_div = r_stride >> 1;
            3'd3:    stride_div = r_stride_div3;
            default: stride_div = r_stride >> 2;
        endcase
    end

    assign ulen = (!r_eight && r_layout == LAYOUT_POL_INTERLV) ? stride_div : r_stride;
    assign len  = (ulen == '0) ? STRIDE_W'(1) : ulen;

    assign cap    = CW'(1) << OB;
    assign bb_ext = CW'(r_block_bytes);
    always_comb begin
        if (bb_ext == '0) begin
            bb_eff = CW'(1);
        end else if (bb_ext > cap) begin
            bb_eff = cap;
        end else begin
            bb_eff = bb_ext;
        end
    end

    assign target_cp = 8'(r_chan) * 8'(npol) + 8'(r_pol);
    assign target_l0 = r_eight ? target_cp : 8'(r_chan);

    assign unit_p1  = (OB + 1)'(r_unit) + 1'b1;
    assign unit_end = PW'(unit_p1) * PW'(r_stride);

    assign time_p1 = (OB + 1)'(r_time) + 1'b1;
    always_comb begin
        case (npol)
            3'd1:    time_span = XW'(time_p1);
            3'd2:    time_span = XW'(time_p1) << 1;
            3'd3:    time_span = (XW'(time_p1) << 1) + XW'(time_p1);
            default: time_span = XW'(time_p1) << 2;
        endcase
    end

    always_comb begin
        sel  = 1'b0;
        tidx = '0;
        if (ulen != '0) begin
            if (r_layout == LAYOUT_TIME_MAJOR) begin
                sel  = (r_pos == OB'(target_l0)) && (unit_end <= PW'(bb_eff));
                tidx = r_unit;
            end else if (r_layout == LAYOUT_CHAN_BLOCKED ||
                         (r_layout == LAYOUT_POL_INTERLV && !r_eight)) begin
                sel  = (r_unit == OB'(target_cp));
                tidx = r_pos;
            end else if (r_layout == LAYOUT_POL_INTERLV) begin
                sel  = (r_unit == OB'(r_chan)) && (r_pol_phase == r_pol) &&
                       (time_span <= XW'(r_stride));
                tidx = r_time;
            end
        end
    end

    assign code = 2'((r_in_byte >> {r_pol, 1'b0}) & 8'd3);
    assign smp  = signed'(r_in_byte);

    always_comb begin
        n_run_min = r_run_min;
        n_run_max = r_run_max;
        val       = '0;
        if (sel) begin
            if (r_eight) begin
                val = {smp, 12'd0};
                if (smp < r_run_min) n_run_min = smp;
                if (smp > r_run_max) n_run_max = smp;
            end else begin
                val = level_q12(code);
            end
        end
    end

    assign done   = (CW'(r_block_offset) + CW'(1)) >= bb_eff;
    assign wrap   = (CW'(r_pos) + CW'(1)) >= CW'(len);
    assign p_emit = sel || done;

    always_comb begin
        n_block_offset = r_block_offset + 1'b1;
        n_pos          = r_pos;
        n_unit         = r_unit;
        n_pol_phase    = r_pol_phase;
        n_time         = r_time;
        if (wrap) begin
            n_pos       = '0;
            n_unit      = r_unit + 1'b1;
            n_pol_phase = '0;
            n_time      = '0;
        end else begin
            n_pos = r_pos + 1'b1;
            if ((3'(r_pol_phase) + 3'd1) >= npol) begin
                n_pol_phase = '0;
                n_time      = r_time + 1'b1;
            end else begin
                n_pol_phase = r_pol_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_block_offset <= '0;
            r_pos          <= '0;
            r_unit         <= '0;
            r_pol_phase    <= '0;
            r_time         <= '0;
            r_run_min      <= RANGE_MIN_INIT;
            r_run_max      <= RANGE_MAX_INIT;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (p_fire) begin
                r_out_valid <= p_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (p_fire) begin
                if (done) begin
                    // block ends: start the next one from scratch
                    r_block_offset <= '0;
                    r_pos          <= '0;
                    r_unit         <= '0;
                    r_pol_phase    <= '0;
                    r_time         <= '0;
                    r_run_min      <= RANGE_MIN_INIT;
                    r_run_max      <= RANGE_MAX_INIT;
                end else begin
                    r_block_offset <= n_block_offset;
                    r_pos          <= n_pos;
                    r_unit         <= n_unit;
                    r_pol_phase    <= n_pol_phase;
                    r_time         <= n_time;
                    r_run_min      <= n_run_min;
                    r_run_max      <= n_run_max;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_payload_byte;
        end
        if (p_fire && p_emit) begin
            r_out_value <= val;
            r_out_code  <= (sel && !r_eight) ? code : 2'd0;
            r_out_index <= sel ? IDX_W'(tidx) : '0;
            r_out_min   <= n_run_min;
            r_out_max   <= n_run_max;
            r_out_done  <= done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_sample_code  = r_out_code;
    assign o_sample_index = r_out_index;
    assign o_range_min    = r_out_min;
    assign o_range_max    = r_out_max;
    assign o_block_done   = r_out_done;

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_fire && done |=> r_block_offset == '0 && r_pos == '0 && r_unit == '0)
        else $error("block counters not cleared after last byte");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_fire && p_emit |=> r_out_valid && r_out_done == $past(done))
        else $error("result not loaded into output register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !p_fire |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte lost or changed");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_fire && !done |=> r_block_offset == $past(r_block_offset) + 1'b1)
        else $error("block offset did not advance");

endmodule

// File: test/raw_voltage_channel_slicer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_voltage_channel_slicer_core_tb
// Streams payload bytes through the channel slicer under many register
// settings and checks every sample request against a cycle-free predictor
// of the channel/polarization selection, the 2-bit and 8-bit decode and the
// block range tracking. Both handshakes idle at random, and one long output
// stall backs the block up into its input.
// ----------------------------------------------------------------------------
module raw_voltage_channel_slicer_core_tb;

    import rvcs_pkg::*;

    localparam int OFFSET_BITS = DEFAULT_OFFSET_BITS;
    localparam longint unsigned BLOCK_CAP = 64'd1 << OFFSET_BITS;
    localparam logic [1:0] LAYOUT_UNUSED = 2'd3;
    localparam logic [STRIDE_W-1:0] REG_MAX = 29'h1FFF_FFFF;
    localparam logic [STRIDE_W-1:0] SIZE_2_28 = 29'h1000_0000;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 4;

    localparam logic signed [VAL_W-1:0] CODE_LEVEL [4] = '{
        -20'sd13664, -20'sd4096, 20'sd4096, 20'sd13664
    };
    localparam logic [7:0] EDGE_BYTES [8] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'hFF, 8'h80, 8'h7F, 8'hAA
    };

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              code;
        logic [IDX_W-1:0]        index;
        logic signed [7:0]       lo;
        logic signed [7:0]       hi;
        logic                    done;
    } sample_t;

    class slicer_scoreboard;
        logic                eight_mode;
        logic [1:0]          layout;
        logic [5:0]          chan;
        logic [1:0]          pol;
        logic [2:0]          npol_reg;
        logic [STRIDE_W-1:0] stride;
        logic [STRIDE_W-1:0] blk_len;

        logic [IDX_W-1:0]    blk_off;
        logic [IDX_W-1:0]    unit_pos;
        logic [IDX_W-1:0]    unit_num;
        logic [IDX_W-1:0]    time_idx;
        logic [1:0]          pol_phase;
        logic signed [7:0]   run_min;
        logic signed [7:0]   run_max;

        sample_t expected_samples[$];
        int errors;
        int n_bytes;
        int n_samples;
        int n_block_ends;

        function new();
            eight_mode = 1'b0;
            layout     = LAYOUT_TIME_MAJOR;
            chan       = '0;
            pol        = '0;
            npol_reg   = RST_NPOL;
            stride     = RST_STRIDE;
            blk_len    = RST_BLOCK_BYTES;
            errors     = 0;
            n_bytes    = 0;
            n_samples  = 0;
            n_block_ends = 0;
            clear_block();
        endfunction

        function void clear_block();
            blk_off   = '0;
            unit_pos  = '0;
            unit_num  = '0;
            time_idx  = '0;
            pol_phase = '0;
            run_min   = RANGE_MIN_INIT;
            run_max   = RANGE_MAX_INIT;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [STRIDE_W-1:0] data);
            case (idx)
                CFG_EIGHT_BIT_MODE:        eight_mode = data[0];
                CFG_LAYOUT_SELECT:         layout     = data[1:0];
                CFG_SELECTED_CHANNEL:      chan       = data[5:0];
                CFG_SELECTED_POLARIZATION: pol        = data[1:0];
                CFG_POLS_PER_CHANNEL:      npol_reg   = data[2:0];
                CFG_STRIDE_BYTES:          stride     = data;
                CFG_BLOCK_BYTES:           blk_len    = data;
                default: ;
            endcase
        endfunction

        // Predict the sample request (if any) caused by one payload byte.
        function void note_request(logic [7:0] b);
            longint unsigned np, ulen, bb, len, tgt;
            bit sel, done;
            logic [IDX_W-1:0] tidx;
            logic [1:0] code;
            logic signed [VAL_W-1:0] val;
            logic signed [7:0] s;
            sample_t smp;

            n_bytes++;
            np = (npol_reg == 3'd0) ? 64'd1 : (npol_reg > 3'd4) ? 64'd4 : 64'(npol_reg);
            ulen = (!eight_mode && layout == LAYOUT_POL_INTERLV) ?
                   64'(stride) / np : 64'(stride);
            bb = (blk_len == '0) ? 64'd1 : 64'(blk_len);
            if (bb > BLOCK_CAP) bb = BLOCK_CAP;
            sel  = 1'b0;
            tidx = '0;
            code = '0;
            val  = '0;

            if (ulen != 0) begin
                if (layout == LAYOUT_TIME_MAJOR) begin
                    tgt  = eight_mode ? 64'(chan) * np + 64'(pol) : 64'(chan);
                    sel  = (64'(unit_pos) == tgt) &&
                           ((64'(unit_num) + 64'd1) * 64'(stride) <= bb);
                    tidx = unit_num;
                end else if (layout == LAYOUT_CHAN_BLOCKED ||
                             (layout == LAYOUT_POL_INTERLV && !eight_mode)) begin
                    sel  = (64'(unit_num) == 64'(chan) * np + 64'(pol));
                    tidx = unit_pos;
                end else if (layout == LAYOUT_POL_INTERLV) begin
                    sel  = (64'(unit_num) == 64'(chan)) && (pol_phase == pol) &&
                           ((64'(time_idx) + 64'd1) * np <= 64'(stride));
                    tidx = time_idx;
                end
            end

            if (sel) begin
                if (eight_mode) begin
                    s   = b;
                    val = {s, 12'd0};
                    if (s < run_min) run_min = s;
                    if (s > run_max) run_max = s;
                end else begin
                    code = b[2*pol +: 2];
                    val  = CODE_LEVEL[code];
                end
            end

            done = (64'(blk_off) + 64'd1) >= bb;

            if (sel || done) begin
                smp.value = val;
                smp.code  = code;
                smp.index = sel ? tidx : '0;
                smp.lo    = run_min;
                smp.hi    = run_max;
                smp.done  = done;
                expected_samples.push_back(smp);
                n_samples++;
                if (done) n_block_ends++;
            end

            if (done) begin
                clear_block();
            end else begin
                len = (ulen != 0) ? ulen : 64'd1;
                blk_off = blk_off + 1'b1;
                if (64'(unit_pos) + 64'd1 >= len) begin
                    unit_pos  = '0;
                    unit_num  = unit_num + 1'b1;
                    pol_phase = '0;
                    time_idx  = '0;
                end else begin
                    unit_pos = unit_pos + 1'b1;
                    if (64'(pol_phase) + 64'd1 >= np) begin
                        pol_phase = '0;
                        time_idx  = time_idx + 1'b1;
                    end else begin
                        pol_phase = pol_phase + 1'b1;
                    end
                end
            end
        endfunction

        function void check_result(sample_t got);
            sample_t exp_s;
            if (expected_samples.size() == 0) begin
                $error("unexpected sample request: value %0d index %0d done %0b",
                       got.value, got.index, got.done);
                errors++;
                return;
            end
            exp_s = expected_samples.pop_front();
            if (got.value !== exp_s.value) begin
                $error("sample_value: expected %0d, got %0d", exp_s.value, got.value);
                errors++;
            end
            if (got.code !== exp_s.code) begin
                $error("sample_code: expected %0d, got %0d", exp_s.code, got.code);
                errors++;
            end
            if (got.index !== exp_s.index) begin
                $error("sample_index: expected %0d, got %0d", exp_s.index, got.index);
                errors++;
            end
            if (got.lo !== exp_s.lo) begin
                $error("range_min: expected %0d, got %0d", exp_s.lo, got.lo);
                errors++;
            end
            if (got.hi !== exp_s.hi) begin
                $error("range_max: expected %0d, got %0d", exp_s.hi, got.hi);
                errors++;
            end
            if (got.done !== exp_s.done) begin
                $error("block_done: expected %0b, got %0b", exp_s.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [STRIDE_W-1:0]     i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [7:0]              i_payload_byte = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_sample_value;
    logic [1:0]              o_sample_code;
    logic [IDX_W-1:0]        o_sample_index;
    logic signed [7:0]       o_range_min;
    logic signed [7:0]       o_range_max;
    logic                    o_block_done;

    slicer_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    int n_settings = 0;
    int idle_cycles = 0;

    raw_voltage_channel_slicer_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_sample_code  (o_sample_code),
        .o_sample_index (o_sample_index),
        .o_range_min    (o_range_min),
        .o_range_max    (o_range_max),
        .o_block_done   (o_block_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Output side: random ready pattern, calm stretches and one long hold-off.
    initial begin
        int r;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    if (r < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    else repeat ($urandom_range(10, 30)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : sample_monitor
        sample_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.value = o_sample_value;
            got.code  = o_sample_code;
            got.index = o_sample_index;
            got.lo    = o_range_min;
            got.hi    = o_range_max;
            got.done  = o_block_done;
            sb.check_result(got);
        end
    end

    // Give up when neither side has moved a request for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic put_reg(input t_cfg_idx idx, input logic [STRIDE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic mode, input logic [1:0] lay,
                                input logic [5:0] ch, input logic [1:0] pl,
                                input logic [2:0] np, input logic [STRIDE_W-1:0] str,
                                input logic [STRIDE_W-1:0] blk);
        put_reg(CFG_EIGHT_BIT_MODE, STRIDE_W'(mode));
        put_reg(CFG_LAYOUT_SELECT, STRIDE_W'(lay));
        put_reg(CFG_SELECTED_CHANNEL, STRIDE_W'(ch));
        put_reg(CFG_SELECTED_POLARIZATION, STRIDE_W'(pl));
        put_reg(CFG_POLS_PER_CHANNEL, STRIDE_W'(np));
        put_reg(CFG_STRIDE_BYTES, str);
        put_reg(CFG_BLOCK_BYTES, blk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic stream_bytes(input int n, input bit directed);
        logic [7:0] b;
        int gap;
        for (int k = 0; k < n; k++) begin
            b   = directed ? EDGE_BYTES[k % 8] : 8'($urandom);
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid     <= 1'b1;
            i_payload_byte <= b;
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_request(b);
        end
        i_in_valid <= 1'b0;
    endtask

    // Drain all expected samples, then let bytes without a result clear the pipe.
    task automatic wait_idle();
        while (sb.expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] lay;
        logic [5:0] ch;
        logic [2:0] np;
        logic [STRIDE_W-1:0] str, blk;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all four 2-bit codes, chan/pol-blocked
        program_regs(1'b0, LAYOUT_CHAN_BLOCKED, 6'd0, 2'd0, 3'd1, 29'd8, 29'd6);
        stream_bytes(6, 1'b1);
        wait_idle();
        // 8-bit pol-interleaved, one full block
        program_regs(1'b1, LAYOUT_POL_INTERLV, 6'd1, 2'd1, 3'd2, 29'd4, 29'd8);
        stream_bytes(8, 1'b1);
        wait_idle();
        // zero unit length, oversized pol count
        program_regs(1'b0, LAYOUT_TIME_MAJOR, 6'd0, 2'd2, 3'd5, 29'd0, 29'd3);
        stream_bytes(4, 1'b1);
        wait_idle();
        // unused layout, zero block size and zero pol count: every byte ends a block
        program_regs(1'b0, LAYOUT_UNUSED, 6'd0, 2'd0, 3'd0, 29'd16, 29'd0);
        stream_bytes(4, 1'b1);
        wait_idle();

        // widest stride and an oversized block
        program_regs(1'b1, LAYOUT_CHAN_BLOCKED, 6'd0, 2'd0, 3'd1, REG_MAX, REG_MAX);
        stream_bytes(20, 1'b0);
        wait_idle();
        program_regs(1'b1, LAYOUT_POL_INTERLV, 6'd0, 2'd3, 3'd4, SIZE_2_28, SIZE_2_28);
        stream_bytes(20, 1'b0);
        wait_idle();
        // top channel, counters wrap at the block end into the next block
        program_regs(1'b0, LAYOUT_TIME_MAJOR, 6'd63, 2'd3, 3'd7, 29'd64, 29'd128);
        stream_bytes(130, 1'b0);
        wait_idle();

        // long output stall with the sender pushing back to back
        program_regs(1'b1, LAYOUT_CHAN_BLOCKED, 6'd0, 2'd0, 3'd1, 29'd1, 29'd1);
        calm = 1'b1;
        hold_off_req = 1'b1;
        stream_bytes(40, 1'b0);
        wait_idle();
        calm = 1'b0;

        for (int p = 0; p < 12; p++) begin
            lay = 2'($urandom_range(0, 3));
            ch  = 6'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 63));
            np  = 3'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) :
                                                    $urandom_range(0, 7));
            case ($urandom_range(0, 19))
                0:       str = '0;
                1, 2:    str = STRIDE_W'($urandom_range(17, 300));
                default: str = STRIDE_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 19))
                0:       blk = '0;
                1, 2:    blk = STRIDE_W'($urandom_range(65, 600));
                default: blk = STRIDE_W'($urandom_range(1, 64));
            endcase
            program_regs(1'($urandom_range(0, 1)), lay, ch, 2'($urandom_range(0, 3)),
                         np, str, blk);
            calm = (p == 3);
            stream_bytes(30, 1'b0);
            wait_idle();
        end
        calm = 1'b0;

        $display("Covered %0d payload bytes under %0d register settings:",
                 sb.n_bytes, n_settings);
        $display("  %0d samples checked, %0d block ends", sb.n_samples, sb.n_block_ends);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rvcs_pkg.sv
rtl/raw_voltage_channel_slicer_core.sv
test/raw_voltage_channel_slicer_core_tb.sv
